// ===== hw/rtl/tdjm_pkg.sv =====
// ---------------------------------------------------------------------------
// tdjm_pkg
// shared types and constants of the task deadline and jitter monitor
// ---------------------------------------------------------------------------
package tdjm_pkg;

   localparam int TASK_SLOTS = 8;
   localparam int SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int MEAN_W     = 48;
   localparam int SPREAD_W   = 64;
   localparam int CNT_W      = 32;
   localparam int STEP_W     = $clog2(MEAN_W + 1);
   localparam int ADDR_W     = 4;

   localparam logic [1:0] REG_REGISTERED = 2'd0;
   localparam logic [1:0] REG_TRIGGER    = 2'd1;
   localparam logic [1:0] REG_HEAVY      = 2'd2;
   localparam logic [1:0] REG_PENALTY    = 2'd3;

   typedef struct packed {
      logic [7:0]  registered_mask;
      logic [7:0]  trigger_mask;
      logic [7:0]  heavy_mask;
      logic [15:0] penalty_amount;
   } cfg_type;

   typedef struct packed {
      logic [CNT_W-1:0]    job_count;
      logic [CNT_W-1:0]    miss_count;
      logic [MEAN_W-1:0]   mean;
      logic [SPREAD_W-1:0] spread;
   } stats_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] addr;
      stats_type         data;
   } store_wr_type;

endpackage

// ===== hw/rtl/tdjm_if.sv =====
// ---------------------------------------------------------------------------
// tdjm channel interfaces
// event word in, statistics word out, valid/ready handshake
// ---------------------------------------------------------------------------
interface tdjm_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  task_id;
   logic [31:0] now_tick;
   logic [31:0] previous_wake_time;
   logic [31:0] time_increment;

   modport source (output valid, task_id, now_tick, previous_wake_time, time_increment,
                   input ready);
   modport sink   (input valid, task_id, now_tick, previous_wake_time, time_increment,
                   output ready);
endinterface

interface tdjm_rsp_if;
   logic        valid;
   logic        ready;
   logic        accepted;
   logic        deadline_missed;
   logic [31:0] deadline_tick;
   logic [31:0] job_count;
   logic [31:0] miss_count;
   logic [47:0] mean_response;
   logic [63:0] spread_sum;
   logic        contention_charged;
   logic [31:0] penalty_total;

   modport source (output valid, accepted, deadline_missed, deadline_tick, job_count,
                   miss_count, mean_response, spread_sum, contention_charged,
                   penalty_total, input ready);
   modport sink   (input valid, accepted, deadline_missed, deadline_tick, job_count,
                   miss_count, mean_response, spread_sum, contention_charged,
                   penalty_total, output ready);
endinterface

// ===== hw/rtl/task_deadline_jitter_monitor.sv =====
// ---------------------------------------------------------------------------
// task_deadline_jitter_monitor
// per-task deadline miss counting and running response mean and spread
//
//   channel   direction  word
//   req_ch    in         task id, current tick, wake tick, period
//   rsp_ch    out        counts, mean, spread, penalty
//   csr_*     in/out     apb register port, four registers
//
// an accepted word goes through read, load, 48 divide steps, update,
// 48 multiply steps and write back; a rejected word goes straight from
// the request register to the output register.
// one word is worked on at a time; a finished word waits in the output
// register while the next word is taken. reset is synchronous and clears
// all statistics through per-entry valid bits, with no clearing pass.
// ---------------------------------------------------------------------------
module task_deadline_jitter_monitor
   import tdjm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   tdjm_req_if.sink          req_ch,
   tdjm_rsp_if.source        rsp_ch,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_READ = 7'b0000010,
      ST_LOAD = 7'b0000100,
      ST_DIV  = 7'b0001000,
      ST_CALC = 7'b0010000,
      ST_MUL  = 7'b0100000,
      ST_FIN  = 7'b1000000
   } state_type;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   cfg_type             cfg;
   state_type           state_ff;
   state_type           state_in;
   stats_type           rd_data;
   store_wr_type        wr;

   logic [7:0]          id_ff;
   logic [31:0]         now_ff;
   logic [31:0]         wake_ff;
   logic [31:0]         period_ff;
   logic                acc_ff;
   logic [31:0]         deadline_ff;
   logic                missed_ff;
   stats_type           old_ff;
   logic [CNT_W-1:0]    job_ff;
   logic [CNT_W-1:0]    miss_ff;
   logic [MEAN_W-1:0]   r_ff;
   logic                neg_ff;
   logic [MEAN_W-1:0]   mag_ff;
   logic [MEAN_W-1:0]   mean2_ff;
   logic [2:0]          last_ff;
   logic [31:0]         pen_ff;

   logic                rsp_valid_ff;
   logic                rsp_acc_ff;
   logic                rsp_missed_ff;
   logic [31:0]         rsp_next_ff;
   logic [31:0]         rsp_job_ff;
   logic [31:0]         rsp_miss_ff;
   logic [47:0]         rsp_mean_ff;
   logic [63:0]         rsp_spread_ff;
   logic                rsp_charged_ff;
   logic [31:0]         rsp_pen_ff;

   logic                take;
   logic                id_ok;
   logic [31:0]         deadline;
   logic [31:0]         diff;
   logic [CNT_W-1:0]    job_nx;
   logic                neg_nx;
   logic [MEAN_W-1:0]   mag_nx;
   logic [MEAN_W-1:0]   mean2;
   logic [MEAN_W-1:0]   m2_nx;
   logic                div_done;
   logic [MEAN_W-1:0]   step;
   logic                mul_done;
   logic [2*MEAN_W-1:0] prod;
   logic [SPREAD_W:0]   sp_sum;
   logic [SPREAD_W-1:0] sp_new;
   logic                charged;
   logic [32:0]         pen_sum;
   logic [31:0]         pen_new;
   logic                fin_go;

   tdjm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tdjm_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (id_ff[SLOT_W-1:0]),
      .rd_data (rd_data),
      .wr      (wr)
   );

   tdjm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == ST_LOAD),
      .dividend (mag_nx),
      .divisor  (job_nx),
      .done     (div_done),
      .quotient (step)
   );

   tdjm_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (state_ff == ST_CALC),
      .op_a    (mag_ff),
      .op_b    (m2_nx),
      .done    (mul_done),
      .product (prod)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign take         = req_ch.valid && req_ch.ready;
   assign id_ok        = (32'(req_ch.task_id) < 32'(TASK_SLOTS)) && (req_ch.task_id < 8'd8)
                         && cfg.registered_mask[req_ch.task_id[2:0]];

   assign deadline = wake_ff + period_ff;
   assign diff     = now_ff - deadline;
   assign job_nx   = (rd_data.job_count == CNT_MAX) ? CNT_MAX : rd_data.job_count + 1'b1;
   assign neg_nx   = r_ff < rd_data.mean;
   assign mag_nx   = neg_nx ? rd_data.mean - r_ff : r_ff - rd_data.mean;
   assign mean2    = neg_ff ? old_ff.mean - step : old_ff.mean + step;
   assign m2_nx    = neg_ff ? mean2 - r_ff : r_ff - mean2;

   always_comb begin
      sp_sum  = {1'b0, old_ff.spread} + {1'b0, prod[SPREAD_W+15:16]};
      if ((prod[2*MEAN_W-1:SPREAD_W+16] != '0) || sp_sum[SPREAD_W]) begin
         sp_new = '1;
      end else begin
         sp_new = sp_sum[SPREAD_W-1:0];
      end
      charged = acc_ff && cfg.trigger_mask[id_ff[2:0]] && cfg.heavy_mask[last_ff];
      pen_sum = {1'b0, pen_ff} + {17'd0, cfg.penalty_amount};
      pen_new = charged ? (pen_sum[32] ? '1 : pen_sum[31:0]) : pen_ff;
   end

   assign fin_go = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      wr.en          = fin_go && acc_ff;
      wr.addr        = id_ff[SLOT_W-1:0];
      wr.data.job_count  = job_ff;
      wr.data.miss_count = miss_ff;
      wr.data.mean       = mean2_ff;
      wr.data.spread     = sp_new;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (take) state_in = id_ok ? ST_READ : ST_FIN;
         ST_READ: state_in = ST_LOAD;
         ST_LOAD: state_in = ST_DIV;
         ST_DIV:  if (div_done) state_in = ST_CALC;
         ST_CALC: state_in = ST_MUL;
         ST_MUL:  if (mul_done) state_in = ST_FIN;
         ST_FIN:  if (fin_go) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (take) begin
         id_ff     <= req_ch.task_id;
         now_ff    <= req_ch.now_tick;
         wake_ff   <= req_ch.previous_wake_time;
         period_ff <= req_ch.time_increment;
         acc_ff    <= id_ok;
      end
      if (state_ff == ST_READ) begin
         deadline_ff <= deadline;
         missed_ff   <= (diff != '0) && !diff[31];
         r_ff        <= {now_ff - wake_ff, 16'd0};
      end
      if (state_ff == ST_LOAD) begin
         old_ff  <= rd_data;
         job_ff  <= job_nx;
         miss_ff <= (missed_ff && rd_data.miss_count != CNT_MAX)
                    ? rd_data.miss_count + 1'b1 : rd_data.miss_count;
         neg_ff  <= neg_nx;
         mag_ff  <= mag_nx;
      end
      if (state_ff == ST_CALC) begin
         mean2_ff <= mean2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         last_ff  <= '0;
         pen_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (fin_go && acc_ff) begin
            last_ff <= id_ff[2:0];
            pen_ff  <= pen_new;
         end
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fin_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_go) begin
         rsp_acc_ff     <= acc_ff;
         rsp_missed_ff  <= acc_ff && missed_ff;
         rsp_next_ff    <= acc_ff ? deadline_ff : '0;
         rsp_job_ff     <= acc_ff ? job_ff : '0;
         rsp_miss_ff    <= acc_ff ? miss_ff : '0;
         rsp_mean_ff    <= acc_ff ? mean2_ff : '0;
         rsp_spread_ff  <= acc_ff ? sp_new : '0;
         rsp_charged_ff <= charged;
         rsp_pen_ff     <= acc_ff ? pen_new : pen_ff;
      end
   end

   assign rsp_ch.valid              = rsp_valid_ff;
   assign rsp_ch.accepted           = rsp_acc_ff;
   assign rsp_ch.deadline_missed    = rsp_missed_ff;
   assign rsp_ch.deadline_tick      = rsp_next_ff;
   assign rsp_ch.job_count          = rsp_job_ff;
   assign rsp_ch.miss_count         = rsp_miss_ff;
   assign rsp_ch.mean_response      = rsp_mean_ff;
   assign rsp_ch.spread_sum         = rsp_spread_ff;
   assign rsp_ch.contention_charged = rsp_charged_ff;
   assign rsp_ch.penalty_total      = rsp_pen_ff;

endmodule

// ===== hw/rtl/tdjm_csr.sv =====
// ---------------------------------------------------------------------------
// tdjm_csr
// apb register file holding the task masks and the penalty amount
// ---------------------------------------------------------------------------
module tdjm_csr
   import tdjm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg
);

   cfg_type    cfg_ff;
   logic [1:0] idx;

   assign idx        = csr_paddr[ADDR_W-1:2];
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (idx)
            REG_REGISTERED: cfg_ff.registered_mask <= csr_pwdata[7:0];
            REG_TRIGGER:    cfg_ff.trigger_mask    <= csr_pwdata[7:0];
            REG_HEAVY:      cfg_ff.heavy_mask      <= csr_pwdata[7:0];
            REG_PENALTY:    cfg_ff.penalty_amount  <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_REGISTERED: csr_prdata = {24'd0, cfg_ff.registered_mask};
         REG_TRIGGER:    csr_prdata = {24'd0, cfg_ff.trigger_mask};
         REG_HEAVY:      csr_prdata = {24'd0, cfg_ff.heavy_mask};
         REG_PENALTY:    csr_prdata = {16'd0, cfg_ff.penalty_amount};
         default:        csr_prdata = '0;
      endcase
   end

endmodule

// ===== hw/rtl/tdjm_store.sv =====
// ---------------------------------------------------------------------------
// tdjm_store
// per-task statistics memory, registered read, valid bit per entry
// ---------------------------------------------------------------------------
module tdjm_store
   import tdjm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [SLOT_W-1:0] rd_addr,
   output stats_type         rd_data,
   input  store_wr_type      wr
);

   stats_type               mem [TASK_SLOTS];
   logic [TASK_SLOTS-1:0]   valid_ff;
   stats_type               rd_data_ff;
   logic                    rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

// ===== hw/rtl/tdjm_div.sv =====
// ---------------------------------------------------------------------------
// tdjm_div
// restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
module tdjm_div
   import tdjm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [MEAN_W-1:0] dividend,
   input  logic [CNT_W-1:0]  divisor,
   output logic              done,
   output logic [MEAN_W-1:0] quotient
);

   logic [MEAN_W-1:0] quo_ff;
   logic [MEAN_W-1:0] quo_in;
   logic [CNT_W-1:0]  rem_ff;
   logic [CNT_W-1:0]  rem_in;
   logic [CNT_W-1:0]  dsr_ff;
   logic [STEP_W-1:0] cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W:0]    trial;
   logic [CNT_W:0]    diff;

   always_comb begin
      trial  = {rem_ff, quo_ff[MEAN_W-1]};
      diff   = trial - {1'b0, dsr_ff};
      if (!diff[CNT_W]) begin
         rem_in = diff[CNT_W-1:0];
         quo_in = {quo_ff[MEAN_W-2:0], 1'b1};
      end else begin
         rem_in = trial[CNT_W-1:0];
         quo_in = {quo_ff[MEAN_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == STEP_W'(MEAN_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== hw/rtl/tdjm_mul.sv =====
// ---------------------------------------------------------------------------
// tdjm_mul
// shift-add multiplier, one multiplier bit per cycle, full product
// ---------------------------------------------------------------------------
module tdjm_mul
   import tdjm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [MEAN_W-1:0]   op_a,
   input  logic [MEAN_W-1:0]   op_b,
   output logic                done,
   output logic [2*MEAN_W-1:0] product
);

   logic [2*MEAN_W-1:0] acc_ff;
   logic [MEAN_W-1:0]   a_ff;
   logic [MEAN_W-1:0]   b_ff;
   logic [STEP_W-1:0]   cnt_ff;
   logic                busy_ff;
   logic                done_ff;
   logic [MEAN_W:0]     sum;

   assign sum = {1'b0, acc_ff[2*MEAN_W-1:MEAN_W]} + (b_ff[0] ? {1'b0, a_ff} : '0);

   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff <= '0;
         a_ff   <= op_a;
         b_ff   <= op_b;
      end else if (busy_ff) begin
         acc_ff <= {sum, acc_ff[MEAN_W-1:1]};
         b_ff   <= {1'b0, b_ff[MEAN_W-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == STEP_W'(MEAN_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule
